[sv/gmri_pkg.sv]
// Shared widths, register indexes and defaults for the gyro rate integrator.
`timescale 1ns / 1ps

package gmri_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int RATE_W      = 24;
    localparam int ANGLE_W     = 64;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int PROD_W      = RATE_W + CFG_W;
    localparam int RATE_SHIFT  = 8;
    localparam int ANGLE_SHIFT = 8;
    localparam int INC_W       = PROD_W - ANGLE_SHIFT;

    // multiplier digit width; must divide CFG_W
    localparam int DIGIT_W_DEF = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT       = 2'd2;

    localparam logic [CFG_W-1:0] RATE_GAIN_RST   = 16'd17855;
    localparam logic [CFG_W-1:0] STEP_PERIOD_RST = 16'd16777;
    localparam logic [CFG_W-1:0] DRIFT_RST       = 16'd7662;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [RATE_W-1:0]   rate_t;
    typedef logic signed [ANGLE_W-1:0]  angle_t;
    typedef logic        [CFG_W-1:0]    cfg_word_t;
    typedef logic signed [PROD_W-1:0]   prod_t;

endpackage

[sv/gmri_window.sv]
// Two-sample history window and median-of-three selection.
`timescale 1ns / 1ps

module gmri_window
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift,
    input  gmri_pkg::sample_t sample,
    output gmri_pkg::sample_t median
);

    import gmri_pkg::*;

    sample_t older_reg;
    sample_t newer_reg;
    sample_t lo;
    sample_t hi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg <= '0;
            newer_reg <= '0;
        end
        else if (shift)
        begin
            older_reg <= newer_reg;
            newer_reg <= sample;
        end
    end

    always_comb
    begin
        lo = (older_reg < newer_reg) ? older_reg : newer_reg;
        hi = (older_reg < newer_reg) ? newer_reg : older_reg;
        if (sample <= lo)
            median = lo;
        else if (sample >= hi)
            median = hi;
        else
            median = sample;
    end

endmodule

[sv/gmri_serial_mul.sv]
// Digit-serial signed x unsigned multiplier, one multiplier digit per cycle.
`timescale 1ns / 1ps

module gmri_serial_mul
#(
    parameter int DIGIT_W = gmri_pkg::DIGIT_W_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  gmri_pkg::rate_t     a,
    input  gmri_pkg::cfg_word_t b,
    output logic                done,
    output gmri_pkg::prod_t     prod
);

    import gmri_pkg::*;

    localparam int STEPS = CFG_W / DIGIT_W;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int ACC_W = RATE_W + DIGIT_W + 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

    rate_t                   a_reg;
    cfg_word_t               b_reg;
    cfg_word_t               b_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    cfg_word_t               lo_reg;
    cfg_word_t               lo_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic signed [DIGIT_W:0]    digit;
    logic signed [ACC_W-1:0]    pp;
    logic signed [ACC_W-1:0]    sum;
    logic [CFG_W+DIGIT_W-1:0]   lo_cat;

    assign digit  = $signed({1'b0, b_reg[DIGIT_W-1:0]});
    assign pp     = ACC_W'(a_reg) * ACC_W'(digit);
    assign sum    = acc_reg + pp;
    // retired low digit enters the product shift register from the top
    assign lo_cat = {sum[DIGIT_W-1:0], lo_reg} >> DIGIT_W;
    assign lo_next  = lo_cat[CFG_W-1:0];
    assign acc_next = sum >>> DIGIT_W;
    assign b_next   = b_reg >> DIGIT_W;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
            lo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            b_reg   <= b_next;
            acc_reg <= acc_next;
            lo_reg  <= lo_next;
        end
    end

    assign done = done_reg;
    assign prod = {acc_reg[RATE_W-1:0], lo_reg};

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("multiplier restarted while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held longer than one cycle");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("done without a running multiply");

endmodule

[sv/gyro_median_rate_integrator_unit.sv]
// Top level: median-of-three gyro filter with rate scaling and angle integration.
// Each sample runs the rate multiply, the angle multiply and the accumulate step before its result is registered;
// a new sample is accepted only in idle, once the previous result has been loaded into the output register;
// both products share one serial multiplier.
// The input is taken again in the same cycle that the result first sits in the output register.
// Reset: configuration registers return to defaults, window and accumulator clear to zero.
`timescale 1ns / 1ps

module gyro_median_rate_integrator_unit
#(
    parameter int DIGIT_W = gmri_pkg::DIGIT_W_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  gmri_pkg::sample_t                    raw_sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output gmri_pkg::sample_t                    median_sample,
    output gmri_pkg::rate_t                      angular_rate,
    output gmri_pkg::angle_t                     heading_angle,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gmri_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  gmri_pkg::cfg_word_t                  cfg_data
);

    import gmri_pkg::*;

    localparam logic [1:0] ST_IDLE      = 2'd0;
    localparam logic [1:0] ST_MUL_RATE  = 2'd1;
    localparam logic [1:0] ST_MUL_ANGLE = 2'd2;
    localparam logic [1:0] ST_ACC       = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    cfg_word_t gain_reg;
    cfg_word_t period_reg;
    cfg_word_t drift_reg;

    sample_t med;
    sample_t med_reg;
    rate_t   rate_reg;
    rate_t   rate_calc;
    angle_t  inc_reg;
    angle_t  inc_calc;
    angle_t  angle_acc_reg;
    angle_t  angle_next;

    sample_t out_med_reg;
    rate_t   out_rate_reg;
    angle_t  out_angle_reg;
    logic    out_valid_reg;

    logic      accept;
    logic      load_out;
    logic      mul_start;
    logic      mul_done;
    rate_t     mul_a;
    cfg_word_t mul_b;
    prod_t     mul_prod;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign load_out  = (state_reg == ST_ACC) && (!out_valid_reg || out_ready);

    gmri_window u_window
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .shift  (accept),
        .sample (raw_sample),
        .median (med)
    );

    // rate = -floor(median * gain / 2^8); increment = floor(rate * period / 2^8) - drift
    assign rate_calc  = -mul_prod[RATE_SHIFT +: RATE_W];
    assign inc_calc   = ANGLE_W'($signed(mul_prod[ANGLE_SHIFT +: INC_W])) - ANGLE_W'(drift_reg);
    assign angle_next = angle_acc_reg + inc_reg;

    assign mul_start = accept || ((state_reg == ST_MUL_RATE) && mul_done);
    assign mul_a     = (state_reg == ST_IDLE) ? RATE_W'(med) : rate_calc;
    assign mul_b     = (state_reg == ST_IDLE) ? gain_reg : period_reg;

    gmri_serial_mul #(.DIGIT_W(DIGIT_W)) u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = ST_MUL_RATE;
            ST_MUL_RATE:
                if (mul_done)
                    state_next = ST_MUL_ANGLE;
            ST_MUL_ANGLE:
                if (mul_done)
                    state_next = ST_ACC;
            ST_ACC:
                if (load_out)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            angle_acc_reg <= '0;
            gain_reg      <= RATE_GAIN_RST;
            period_reg    <= STEP_PERIOD_RST;
            drift_reg     <= DRIFT_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                angle_acc_reg <= angle_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RATE_GAIN:   gain_reg   <= cfg_data;
                    CFG_STEP_PERIOD: period_reg <= cfg_data;
                    CFG_DRIFT:       drift_reg  <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            med_reg <= med;
        if ((state_reg == ST_MUL_RATE) && mul_done)
            rate_reg <= rate_calc;
        if ((state_reg == ST_MUL_ANGLE) && mul_done)
            inc_reg <= inc_calc;
        if (load_out)
        begin
            out_med_reg   <= med_reg;
            out_rate_reg  <= rate_reg;
            out_angle_reg <= angle_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign median_sample = out_med_reg;
    assign angular_rate  = out_rate_reg;
    assign heading_angle = out_angle_reg;

    a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MUL_RATE || state_reg == ST_MUL_ANGLE))
        else $error("multiplier done outside a multiply state");

    a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !load_out |=> $stable(angle_acc_reg))
        else $error("angle accumulator moved without a result load");

    a_out_from_acc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_ACC)
        else $error("result raised outside the accumulate step");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_MUL_RATE)
        else $error("transaction did not start the rate multiply");

endmodule
